/* rtl/mavg_pkg.sv */
package mavg_pkg;

  localparam int unsigned CfgBits  = 7;
  localparam int unsigned AvgBits  = 24;
  localparam int unsigned HeldBits = 7;
  localparam int unsigned FracBits = 8;

  typedef logic [CfgBits-1:0]         window_length_t;
  typedef logic signed [AvgBits-1:0]  average_t;
  typedef logic [HeldBits-1:0]        held_t;

endpackage

/* rtl/mavg_div.sv */
module mavg_div #(
  parameter int unsigned DIVIDEND_W = 30,
  parameter int unsigned DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W);

  logic                  busy_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_q};
    fits    = rem_sh >= {1'b0, divisor_q};
    rem_d   = fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DIVIDEND_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/moving_average_window_top.sv */
// Moving average over the last window_length samples (1 to MAX_WINDOW; zero acts as 1,
// larger values as MAX_WINDOW). Each accepted sample yields one transaction carrying the
// mean in signed Q.8, truncated toward zero and saturated to 24 bits, and the number of
// samples held. Samples live in a single-port ring memory; a running sum and fill count
// sit in flops. Writing window_length clears the history and stalls the input for that
// cycle. One sample is processed at a time: the sample is accepted and the oldest slot
// read, a wait state lets the read data settle, sum and ring are updated, the serial
// divider works out the quotient bit by bit, and the output register is loaded. A stalled
// result holds the next one in the divider stage until the output register frees up.
module moving_average_window_top #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          window_length_we_i,
  input  mavg_pkg::window_length_t      window_length_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mavg_pkg::average_t            average_q8_o,
  output mavg_pkg::held_t               samples_held_o
);

  import mavg_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_WINDOW);
  localparam int unsigned CntW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW  = SAMPLE_BITS + AddrW;
  localparam int unsigned QuoW  = SumW + FracBits;
  localparam int unsigned SatW  = ((QuoW > AvgBits) ? QuoW : AvgBits) + 1;
  localparam logic [SatW-1:0] PosLim = SatW'((1 << (AvgBits - 1)) - 1);
  localparam logic [SatW-1:0] NegLim = SatW'(1 << (AvgBits - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV
  } state_e;

  state_e                   state_q;
  window_length_t           wlen_q;
  logic [CntW-1:0]          slot_q;
  logic [CntW-1:0]          fill_q;
  logic signed [SumW-1:0]   total_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                     neg_q;
  logic                     out_valid_q;
  average_t                 avg_q;
  held_t                    held_q;

  logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] old_q;

  logic [31:0]              wlen_ext;
  logic [CntW-1:0]          win;
  logic                     in_acc;
  logic [CntW-1:0]          slot_eff;
  logic                     full;
  logic [CntW-1:0]          slot_inc;
  logic [CntW-1:0]          slot_d;
  logic [CntW-1:0]          fill_d;
  logic signed [SumW-1:0]   total_d;
  logic [SumW-1:0]          mag;
  logic                     div_start;
  logic                     div_busy;
  logic [QuoW-1:0]          quo;
  logic [SatW-1:0]          quo_ext;
  logic [SatW-1:0]          quo_neg;
  average_t                 avg_d;
  logic                     out_free;
  logic                     out_load;

  always_comb begin
    wlen_ext = 32'(wlen_q);
    if (wlen_ext == 32'd0) begin
      win = CntW'(1);
    end else if (wlen_ext > 32'(MAX_WINDOW)) begin
      win = CntW'(MAX_WINDOW);
    end else begin
      win = CntW'(wlen_ext);
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || window_length_we_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_eff   = (slot_q >= win) ? '0 : slot_q;

  always_comb begin
    full     = fill_q >= win;
    slot_inc = slot_q + CntW'(1);
    slot_d   = (slot_inc >= win) ? '0 : slot_inc;
    fill_d   = full ? win : fill_q + CntW'(1);
    total_d  = total_q - (full ? SumW'(old_q) : '0) + SumW'(sample_q);
    mag      = total_d[SumW-1] ? (~total_d + SumW'(1)) : total_d;
  end

  assign div_start = (state_q == S_UPDATE);

  mavg_div #(
    .DIVIDEND_W (QuoW),
    .DIVISOR_W  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag, FracBits'(0)}),
    .divisor_i  (fill_d),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  always_comb begin
    quo_ext = SatW'(quo);
    quo_neg = ~quo_ext + SatW'(1);
    if (neg_q) begin
      avg_d = (quo_ext > NegLim) ? AvgBits'(NegLim) : quo_neg[AvgBits-1:0];
    end else begin
      avg_d = (quo_ext > PosLim) ? AvgBits'(PosLim) : quo_ext[AvgBits-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_DIV) && !div_busy && out_free;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      old_q <= ring_mem[slot_eff[AddrW-1:0]];
    end
    if (state_q == S_UPDATE) begin
      ring_mem[slot_q[AddrW-1:0]] <= sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= window_length_t'(1);
      slot_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      sample_q    <= '0;
      neg_q       <= 1'b0;
      avg_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (window_length_we_i) begin
        wlen_q  <= window_length_i;
        slot_q  <= '0;
        fill_q  <= '0;
        total_q <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sample_q <= sample_value_i;
            slot_q   <= slot_eff;
            state_q  <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          total_q <= total_d;
          fill_q  <= fill_d;
          slot_q  <= slot_d;
          neg_q   <= total_d[SumW-1];
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            avg_q   <= avg_d;
            held_q  <= HeldBits'(fill_q);
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_q8_o   = avg_q;
  assign samples_held_o = held_q;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_READ)
    else $error("accepted transaction did not start a ring read");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win)
    else $error("fill count beyond window");

  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE |=> div_busy)
    else $error("divider not busy after update");

  a_held_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> samples_held_o != '0)
    else $error("result with no samples held");

endmodule
